// ===== design/flash_record_slot_rotator_top_defines.svh =====
// ----------------------------------------------------------------------------
// Flash record slot rotator assertion macros
// Concurrent assertion helpers that are compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef FLASH_RECORD_SLOT_ROTATOR_TOP_DEFINES_SVH
`define FLASH_RECORD_SLOT_ROTATOR_TOP_DEFINES_SVH

`ifndef SYNTH
`define FRSR_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("frsr assertion failed");
`define FRSR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("frsr assertion failed");
`else
`define FRSR_ASSERT_SAME(label, ante, cons)
`define FRSR_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== design/frsr_pkg.sv =====
// ----------------------------------------------------------------------------
// Flash record slot rotator package
// Shared constants, codes and transaction types of the slot rotator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package frsr_pkg;

	localparam int SECTOR_BYTES = 4096;
	localparam int SECTOR_LOG2  = $clog2(SECTOR_BYTES);
	localparam int OFFSET_W     = SECTOR_LOG2 + 1;
	localparam int RB_W         = 16;
	localparam int SECTOR_W     = 12;
	localparam int ADDR_W       = 24;
	localparam int CFG_W        = 16;

	localparam logic [0:0] REG_RECORD_BYTES = 1'd0;
	localparam logic [0:0] REG_SECTOR_INDEX = 1'd1;

	localparam logic [7:0] FLAG_FREE    = 8'hFF;
	localparam logic [7:0] FLAG_VALID   = 8'h9A;
	localparam logic [7:0] FLAG_INVALID = 8'h00;

	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_SAVE   = 2'd1;
	localparam logic [1:0] OP_FLAG   = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [1:0] CMD_READ  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_ERASE = 2'd2;
	localparam logic [1:0] CMD_DONE  = 2'd3;

	localparam logic [1:0] STS_OK       = 2'd0;
	localparam logic [1:0] STS_BLANK    = 2'd1;
	localparam logic [1:0] STS_ERASED   = 2'd2;
	localparam logic [1:0] STS_SIZE_ERR = 2'd3;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_LOAD,
		MODE_SAVE
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_W_INV,
		ST_W_VALID_HERE,
		ST_ERASE,
		ST_W_VALID_BASE,
		ST_DONE
	} fsm_state_t;

	typedef enum logic [2:0] {
		RES_READ,
		RES_W_INV,
		RES_W_VALID_HERE,
		RES_ERASE,
		RES_W_VALID_BASE,
		RES_DONE
	} res_kind_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] flag_value;
	} in_item_t;

	typedef struct packed {
		logic [1:0]        command;
		logic [ADDR_W-1:0] flash_address;
		logic [7:0]        flag_to_write;
		logic [1:0]        status;
		logic              last;
	} out_item_t;

	typedef struct packed {
		logic      clear;
		logic      advance;
		logic      capture;
		logic      emit;
		res_kind_t kind;
		logic [1:0] status;
	} dp_cmd_t;

	typedef struct packed {
		logic size_ok;
		logic wrap;
		logic flag_free;
		logic flag_valid;
	} dp_stat_t;

endpackage

// ===== design/frsr_datapath.sv =====
// ----------------------------------------------------------------------------
// Flash record slot rotator datapath
// Holds the configuration, the slot offset and builds the result fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frsr_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [0:0]                 cfg_index,
	input  logic [frsr_pkg::CFG_W-1:0] cfg_data,
	input  logic [7:0]                 flag_value,
	input  frsr_pkg::dp_cmd_t          cmd,
	output frsr_pkg::dp_stat_t         stat,
	output frsr_pkg::out_item_t        result
);
	import frsr_pkg::*;

	localparam int CMP_W = RB_W + 1;

	logic [RB_W-1:0]     record_bytes_q;
	logic [SECTOR_W-1:0] sector_index_q;
	logic [OFFSET_W-1:0] offset_q;
	logic [ADDR_W-1:0]   here_q;
	logic [OFFSET_W-1:0] slot_size;
	logic [OFFSET_W-1:0] next_offset;
	logic [ADDR_W-1:0]   base_addr;
	logic [ADDR_W-1:0]   read_addr;

	always_comb begin
		slot_size = OFFSET_W'(SECTOR_BYTES);
		for (int k = SECTOR_LOG2; k >= 0; k--) begin
			if ({1'b0, record_bytes_q} <= (CMP_W'(1) << k)) begin
				slot_size = OFFSET_W'(1) << k;
			end
		end
	end

	assign next_offset = offset_q + slot_size;
	assign base_addr   = ADDR_W'(sector_index_q) << SECTOR_LOG2;
	assign read_addr   = base_addr + ADDR_W'(offset_q) + ADDR_W'(record_bytes_q) - ADDR_W'(1);

	assign stat.size_ok    = (record_bytes_q != '0) &&
		({1'b0, record_bytes_q} <= CMP_W'(SECTOR_BYTES));
	assign stat.wrap       = next_offset >= OFFSET_W'(SECTOR_BYTES);
	assign stat.flag_free  = flag_value == FLAG_FREE;
	assign stat.flag_valid = flag_value == FLAG_VALID;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			record_bytes_q <= RB_W'(16);
			sector_index_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RECORD_BYTES: record_bytes_q <= cfg_data[RB_W-1:0];
				REG_SECTOR_INDEX: sector_index_q <= cfg_data[SECTOR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (cmd.clear) begin
			offset_q <= '0;
		end else if (cmd.advance) begin
			offset_q <= next_offset;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			here_q <= base_addr + ADDR_W'(offset_q);
		end
	end

	always_comb begin
		result.command       = CMD_READ;
		result.flash_address = '0;
		result.flag_to_write = FLAG_INVALID;
		result.status        = STS_OK;
		result.last          = 1'b0;
		unique case (cmd.kind)
			RES_READ: begin
				result.flash_address = read_addr;
				result.last          = 1'b1;
			end
			RES_W_INV: begin
				result.command       = CMD_WRITE;
				result.flash_address = here_q;
			end
			RES_W_VALID_HERE: begin
				result.command       = CMD_WRITE;
				result.flash_address = here_q;
				result.flag_to_write = FLAG_VALID;
			end
			RES_ERASE: begin
				result.command       = CMD_ERASE;
				result.flash_address = base_addr;
			end
			RES_W_VALID_BASE: begin
				result.command       = CMD_WRITE;
				result.flash_address = base_addr;
				result.flag_to_write = FLAG_VALID;
			end
			RES_DONE: begin
				result.command = CMD_DONE;
				result.status  = cmd.status;
				result.last    = 1'b1;
			end
			default: ;
		endcase
	end

endmodule

// ===== design/frsr_ctrl.sv =====
// ----------------------------------------------------------------------------
// Flash record slot rotator controller
// Sequences the commands of one transaction, one result per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frsr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [1:0]         opcode,
	input  frsr_pkg::dp_stat_t stat,
	output frsr_pkg::dp_cmd_t  cmd,
	output logic               busy
);
	import frsr_pkg::*;

	fsm_state_t state_q, state_d;
	mode_t      mode_q, mode_d;
	logic [1:0] status_q, status_d;
	logic       wrap_q, wrap_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			mode_q   <= MODE_IDLE;
			status_q <= STS_OK;
			wrap_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			mode_q   <= mode_d;
			status_q <= status_d;
			wrap_q   <= wrap_d;
		end
	end

	assign busy = state_q != ST_IDLE;

	always_comb begin
		state_d     = state_q;
		mode_d      = mode_q;
		status_d    = status_q;
		wrap_d      = wrap_q;
		cmd.clear   = 1'b0;
		cmd.advance = 1'b0;
		cmd.capture = 1'b0;
		cmd.emit    = 1'b0;
		cmd.kind    = RES_READ;
		cmd.status  = status_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					case (opcode)
						OP_LOAD, OP_SAVE: begin
							cmd.clear = 1'b1;
							if (!stat.size_ok) begin
								status_d = STS_SIZE_ERR;
								state_d  = ST_DONE;
							end else begin
								mode_d  = (opcode == OP_LOAD) ? MODE_LOAD : MODE_SAVE;
								state_d = ST_READ;
							end
						end
						OP_FLAG: begin
							if (mode_q != MODE_IDLE) begin
								if (!stat.size_ok) begin
									status_d = STS_SIZE_ERR;
									state_d  = ST_DONE;
								end else if (mode_q == MODE_LOAD) begin
									if (stat.flag_free) begin
										status_d = STS_BLANK;
										state_d  = ST_DONE;
									end else if (stat.flag_valid) begin
										status_d = STS_OK;
										state_d  = ST_DONE;
									end else begin
										cmd.advance = 1'b1;
										status_d    = STS_ERASED;
										state_d     = stat.wrap ? ST_ERASE : ST_READ;
									end
								end else begin
									status_d = STS_OK;
									if (stat.flag_free) begin
										state_d = ST_W_VALID_HERE;
									end else begin
										cmd.advance = 1'b1;
										wrap_d      = stat.wrap;
										if (stat.flag_valid) begin
											state_d = ST_W_INV;
										end else begin
											state_d = stat.wrap ? ST_ERASE : ST_READ;
										end
									end
								end
							end
						end
						default: ;
					endcase
				end
			end
			ST_READ: begin
				cmd.emit = 1'b1;
				cmd.kind = RES_READ;
				state_d  = ST_IDLE;
			end
			ST_W_INV: begin
				cmd.emit = 1'b1;
				cmd.kind = RES_W_INV;
				state_d  = wrap_q ? ST_ERASE : ST_READ;
			end
			ST_W_VALID_HERE: begin
				cmd.emit = 1'b1;
				cmd.kind = RES_W_VALID_HERE;
				state_d  = ST_DONE;
			end
			ST_ERASE: begin
				cmd.emit = 1'b1;
				cmd.kind = RES_ERASE;
				state_d  = (mode_q == MODE_SAVE) ? ST_W_VALID_BASE : ST_DONE;
			end
			ST_W_VALID_BASE: begin
				cmd.emit = 1'b1;
				cmd.kind = RES_W_VALID_BASE;
				state_d  = ST_DONE;
			end
			ST_DONE: begin
				cmd.emit  = 1'b1;
				cmd.kind  = RES_DONE;
				cmd.clear = 1'b1;
				mode_d    = MODE_IDLE;
				state_d   = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== design/flash_record_slot_rotator_top.sv =====
// ----------------------------------------------------------------------------
// Flash record slot rotator
// Rotates one fixed-size record through the power-of-two slots of a sector.
// ----------------------------------------------------------------------------
// A request transaction is taken on a rising edge with start high and busy
// low. Opcode load or save begins a scan and asks for the first flag byte;
// each flag byte that flash returns is sent back with opcode flag. Every
// transaction produces zero to four results on the result port, each marked
// by result_strobe for exactly one cycle, with last set on the final one.
// The first result appears in the cycle after acceptance and the others
// follow on consecutive cycles, with busy high until the last result has
// gone out; the next transaction can be taken in the cycle after the last
// result. Results leave one per cycle through the single result
// port. A flag while no scan runs, or the unused opcode, gives no
// result and leaves busy low. Configuration writes via cfg_we, cfg_index
// and cfg_data take effect at once and belong in idle time. Reset returns
// the block to idle with record size 16 and sector 0. The receiver cannot
// stall, so results are never held.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "flash_record_slot_rotator_top_defines.svh"

module flash_record_slot_rotator_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  frsr_pkg::in_item_t         request,
	output logic                       result_strobe,
	output frsr_pkg::out_item_t        result,
	input  logic                       cfg_we,
	input  logic [0:0]                 cfg_index,
	input  logic [frsr_pkg::CFG_W-1:0] cfg_data
);
	import frsr_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	frsr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (request.opcode),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	frsr_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.flag_value (request.flag_value),
		.cmd        (cmd),
		.stat       (stat),
		.result     (result)
	);

	assign result_strobe = cmd.emit;

	`FRSR_ASSERT_SAME(a_strobe_busy, result_strobe, busy)
	`FRSR_ASSERT_NEXT(a_last_idle, result_strobe && result.last, !busy)
	`FRSR_ASSERT_SAME(a_done_last, result_strobe && (result.command == CMD_DONE), result.last)
	`FRSR_ASSERT_NEXT(a_unused_silent, start && !busy && (request.opcode == OP_UNUSED), !result_strobe)

endmodule
